// ===== rtl/set_lca_binary_lifting_unit_macros.svh =====
// assertion macros for the set lca unit
`ifndef SET_LCA_BINARY_LIFTING_UNIT_MACROS_SVH
`define SET_LCA_BINARY_LIFTING_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SLCA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SLCA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SLCA_ASSERT(label, prop, msg)
`define SLCA_NEVER(label, cond, msg)
`endif

`endif

// ===== rtl/slca_pkg.sv =====
package slca_pkg;

  localparam int NODE_W = 10;
  localparam int TIME_W = 11;
  localparam int LVL_W  = 4;
  localparam int OP_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TIMES = 2'd0,
    OP_LIFT  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    TS_Y   = 2'd0,
    TS_CUR = 2'd1,
    TS_UP  = 2'd2
  } tsel_t;

  typedef enum logic {
    LS_CUR  = 1'b0,
    LS_STEP = 1'b1
  } lsel_t;

  typedef enum logic [1:0] {
    RS_NODE = 2'd0,
    RS_CUR  = 2'd1,
    RS_LIFT = 2'd2
  } rsel_t;

  typedef struct packed {
    logic             wr_times;
    logic             wr_lift;
    logic             load;
    logic             t_rd;
    tsel_t            t_sel;
    logic             cap_ty;
    logic             cap_up;
    logic             l_rd;
    lsel_t            l_sel;
    logic [LVL_W-1:0] lvl;
    logic             upd_cur;
    logic             commit;
    rsel_t            res_sel;
    logic             emit;
  } cmd_t;

  typedef struct packed {
    logic above;
  } status_t;

endpackage

// ===== rtl/slca_ram.sv =====
module slca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/slca_ctrl.sv =====
module slca_ctrl
  import slca_pkg::*;
#(
  parameter int LIFT_LEVELS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [OP_W-1:0] opcode,
  input  logic            is_last,
  input  status_t         st,
  output cmd_t            cmd,
  output logic            busy,
  output logic            done
);

  localparam int KW = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TY,
    S_TX,
    S_AX,
    S_LA,
    S_LC,
    S_FA
  } state_t;

  state_t        state, state_next;
  logic [KW-1:0] k;
  logic          have;
  logic          last;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_TIMES: cmd.wr_times = 1'b1;
            OP_LIFT:  cmd.wr_lift = 1'b1;
            OP_QUERY: begin
              if (have) begin
                cmd.load   = 1'b1;
                state_next = S_TY;
              end else begin
                cmd.commit  = 1'b1;
                cmd.res_sel = RS_NODE;
                cmd.emit    = is_last;
              end
            end
            default: ;
          endcase
        end
      end
      S_TY: begin
        cmd.t_rd   = 1'b1;
        cmd.t_sel  = TS_Y;
        state_next = S_TX;
      end
      S_TX: begin
        cmd.cap_ty = 1'b1;
        cmd.t_rd   = 1'b1;
        cmd.t_sel  = TS_CUR;
        state_next = S_AX;
      end
      S_AX: begin
        if (st.above) begin
          cmd.commit  = 1'b1;
          cmd.res_sel = RS_CUR;
          cmd.emit    = last;
          state_next  = S_IDLE;
        end else begin
          cmd.l_rd   = 1'b1;
          cmd.l_sel  = LS_CUR;
          cmd.lvl    = LVL_W'(LIFT_LEVELS - 1);
          state_next = S_LA;
        end
      end
      S_LA: begin
        cmd.cap_up = 1'b1;
        cmd.t_rd   = 1'b1;
        cmd.t_sel  = TS_UP;
        state_next = S_LC;
      end
      S_LC: begin
        cmd.upd_cur = 1'b1;
        cmd.l_rd    = 1'b1;
        cmd.l_sel   = LS_STEP;
        if (k == '0) begin
          cmd.lvl    = '0;
          state_next = S_FA;
        end else begin
          cmd.lvl    = LVL_W'(k - KW'(1));
          state_next = S_LA;
        end
      end
      S_FA: begin
        cmd.commit  = 1'b1;
        cmd.res_sel = RS_LIFT;
        cmd.emit    = last;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      have  <= 1'b0;
      last  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.commit && cmd.emit;
      if (cmd.commit) begin
        have <= !cmd.emit;
      end
      if (cmd.load) begin
        last <= is_last;
      end
      if (state == S_AX) begin
        k <= KW'(LIFT_LEVELS - 1);
      end else if (state == S_LC && k != '0) begin
        k <= k - KW'(1);
      end
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/slca_dp.sv =====
module slca_dp
  import slca_pkg::*;
#(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           st,
  input  logic [NODE_W-1:0] node,
  input  logic [LVL_W-1:0]  level,
  input  logic [TIME_W-1:0] enter_time,
  input  logic [TIME_W-1:0] leave_time,
  input  logic [NODE_W-1:0] ancestor_node,
  output logic [NODE_W-1:0] common_ancestor
);

  localparam int TAW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int LDEPTH = LIFT_LEVELS * MAX_NODES;
  localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int TW2    = 2 * TIME_W;

  function automatic logic in_range(input logic [NODE_W-1:0] n);
    in_range = 17'(n) < 17'(MAX_NODES);
  endfunction

  function automatic logic [LAW-1:0] lift_addr(input logic [LVL_W-1:0] lv,
                                               input logic [NODE_W-1:0] n);
    lift_addr = LAW'(lv) * LAW'(MAX_NODES) + LAW'(n);
  endfunction

  logic [NODE_W-1:0] y, cur, up, running;
  logic [TIME_W-1:0] ty_in, ty_out;
  logic              t_ok, l_ok;

  logic [TW2-1:0]    t_rdata, tq;
  logic [NODE_W-1:0] l_rdata, lq;
  logic [TIME_W-1:0] tq_in, tq_out;
  logic [NODE_W-1:0] cur_step, t_node, l_node, res;
  logic              above;

  always_comb begin
    tq       = t_ok ? t_rdata : '0;
    tq_in    = tq[TW2-1:TIME_W];
    tq_out   = tq[TIME_W-1:0];
    above    = (tq_in <= ty_in) && (tq_out >= ty_out);
    lq       = l_ok ? l_rdata : '0;
    cur_step = above ? cur : up;
    case (cmd.t_sel)
      TS_Y:    t_node = y;
      TS_CUR:  t_node = cur;
      TS_UP:   t_node = lq;
      default: t_node = y;
    endcase
    case (cmd.l_sel)
      LS_CUR:  l_node = cur;
      LS_STEP: l_node = cur_step;
      default: l_node = cur;
    endcase
    case (cmd.res_sel)
      RS_NODE: res = node;
      RS_CUR:  res = cur;
      RS_LIFT: res = lq;
      default: res = node;
    endcase
  end

  assign st.above = above;

  slca_ram #(
    .WIDTH (TW2),
    .DEPTH (MAX_NODES)
  ) u_time_ram (
    .clk   (clk),
    .we    (cmd.wr_times && in_range(node)),
    .waddr (TAW'(node)),
    .wdata ({enter_time, leave_time}),
    .re    (cmd.t_rd),
    .raddr (TAW'(t_node)),
    .rdata (t_rdata)
  );

  slca_ram #(
    .WIDTH (NODE_W),
    .DEPTH (LDEPTH)
  ) u_lift_ram (
    .clk   (clk),
    .we    (cmd.wr_lift && in_range(node) && (5'(level) < 5'(LIFT_LEVELS))),
    .waddr (lift_addr(level, node)),
    .wdata (ancestor_node),
    .re    (cmd.l_rd),
    .raddr (lift_addr(cmd.lvl, l_node)),
    .rdata (l_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= '0;
    end else if (cmd.commit) begin
      running <= cmd.emit ? '0 : res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y   <= node;
      cur <= running;
    end else if (cmd.upd_cur) begin
      cur <= cur_step;
    end
    if (cmd.t_rd) begin
      t_ok <= in_range(t_node);
    end
    if (cmd.l_rd) begin
      l_ok <= in_range(l_node);
    end
    if (cmd.cap_ty) begin
      ty_in  <= tq_in;
      ty_out <= tq_out;
    end
    if (cmd.cap_up) begin
      up <= lq;
    end
    if (cmd.commit && cmd.emit) begin
      common_ancestor <= res;
    end
  end

endmodule

// ===== rtl/set_lca_binary_lifting_unit.sv =====
// write words never raise busy, and neither does a query word that seeds the set; one
// that closes a one-member set gives its result strobe in the next cycle
// a later member holds busy while it is checked against the running ancestor; if that does
// not cover it, the walk makes one lift read and one time read per level
// result strobe comes in the first cycle with busy low; the receiver cannot stall
// synchronous reset clears the running set; table contents stay undefined until written
`include "set_lca_binary_lifting_unit_macros.svh"

module set_lca_binary_lifting_unit
  import slca_pkg::*;
#(
  parameter int MAX_NODES   = 1024,
  parameter int LIFT_LEVELS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   opcode,
  input  logic [NODE_W-1:0] node,
  input  logic [LVL_W-1:0]  level,
  input  logic [TIME_W-1:0] enter_time,
  input  logic [TIME_W-1:0] leave_time,
  input  logic [NODE_W-1:0] ancestor_node,
  input  logic              is_last,
  output logic              done,
  output logic [NODE_W-1:0] common_ancestor
);

  cmd_t    cmd;
  status_t st;

  slca_ctrl #(
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .opcode  (opcode),
    .is_last (is_last),
    .st      (st),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  slca_dp #(
    .MAX_NODES   (MAX_NODES),
    .LIFT_LEVELS (LIFT_LEVELS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .node            (node),
    .level           (level),
    .enter_time      (enter_time),
    .leave_time      (leave_time),
    .ancestor_node   (ancestor_node),
    .common_ancestor (common_ancestor)
  );

  // a result only follows a walk or a closing query word
  `SLCA_ASSERT(a_done_src, done |-> ($past(busy) || $past(start && opcode == OP_QUERY && is_last)), "result strobe without a query")
  // a walk only starts from an accepted query word
  `SLCA_ASSERT(a_busy_src, (busy && !$past(busy)) |-> $past(start && opcode == OP_QUERY), "busy raised without a query")
  // the result is given as the walk ends
  `SLCA_NEVER(a_done_idle, done && busy, "result strobe while busy")

endmodule

// ===== tb/set_lca_binary_lifting_unit_test.sv =====
`timescale 1ns / 1ps

module set_lca_binary_lifting_unit_test;
  import slca_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int LEVELS = 16;
  localparam int NODES = 1024;
  localparam int MAX_TREE = 16;
  localparam int SETTLE = 2 * LEVELS + 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [NODE_W-1:0] nd;
    logic [LVL_W-1:0]  lv;
    logic [TIME_W-1:0] et;
    logic [TIME_W-1:0] lt;
    logic [NODE_W-1:0] an;
    logic              last;
    logic              typed;
    logic [NODE_W-1:0] want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  logic [OP_W-1:0] opcode = '0;
  logic [NODE_W-1:0] node = '0;
  logic [LVL_W-1:0] level = '0;
  logic [TIME_W-1:0] enter_time = '0;
  logic [TIME_W-1:0] leave_time = '0;
  logic [NODE_W-1:0] ancestor_node = '0;
  logic is_last = 1'b0;
  logic [NODE_W-1:0] common_ancestor;
  logic typed_on = 1'b0;
  logic [NODE_W-1:0] typed_ca = '0;

  logic [TIME_W-1:0] enter_tab [NODES];
  logic [TIME_W-1:0] leave_tab [NODES];
  logic [NODE_W-1:0] lift_tab [LEVELS][NODES];
  logic [NODE_W-1:0] run_anc = '0;
  logic run_open = 1'b0;
  logic [NODE_W-1:0] pending_ancestors [$];
  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 0;

  int tree_size;
  logic [NODE_W-1:0] tree_node [MAX_TREE];
  int tree_par [MAX_TREE];
  bit in_tree [NODES];
  row_t script [$];

  set_lca_binary_lifting_unit DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .node(node),
    .level(level),
    .enter_time(enter_time),
    .leave_time(leave_time),
    .ancestor_node(ancestor_node),
    .is_last(is_last),
    .done(done),
    .common_ancestor(common_ancestor)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit covers(input logic [NODE_W-1:0] x, input logic [NODE_W-1:0] y);
    return enter_tab[x] <= enter_tab[y] && leave_tab[x] >= leave_tab[y];
  endfunction

  function automatic logic [NODE_W-1:0] lowest_common(input logic [NODE_W-1:0] x,
                                                      input logic [NODE_W-1:0] y);
    logic [NODE_W-1:0] cur;
    logic [NODE_W-1:0] up;
    cur = x;
    if (covers(x, y)) return x;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      up = lift_tab[k][cur];
      if (!covers(up, y)) cur = up;
    end
    return lift_tab[0][cur];
  endfunction

  function automatic bit fold_word(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] nd,
                                   input logic [LVL_W-1:0] lv, input logic [TIME_W-1:0] et,
                                   input logic [TIME_W-1:0] lt, input logic [NODE_W-1:0] an,
                                   input logic last, output logic [NODE_W-1:0] res);
    res = '0;
    case (op)
      OP_TIMES: begin
        enter_tab[nd] = et;
        leave_tab[nd] = lt;
        return 1'b0;
      end
      OP_LIFT: begin
        lift_tab[lv][nd] = an;
        return 1'b0;
      end
      OP_QUERY: begin
        if (!run_open) begin
          run_anc = nd;
          run_open = 1'b1;
        end else begin
          run_anc = lowest_common(run_anc, nd);
        end
        if (!last) return 1'b0;
        res = run_anc;
        run_anc = '0;
        run_open = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    logic [NODE_W-1:0] want;
    if (!rst) begin
      if (done) begin
        if (pending_ancestors.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: common_ancestor %0d", common_ancestor);
        end else begin
          want = pending_ancestors.pop_front();
          if (common_ancestor !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("common_ancestor mismatch: expected %0d, got %0d", want, common_ancestor);
          end
        end
      end
      if (start && !busy) begin
        if (fold_word(opcode, node, level, enter_time, leave_time, ancestor_node, is_last, want))
          pending_ancestors.insert(pending_ancestors.size(), typed_on ? typed_ca : want);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("set_lca_binary_lifting_unit test failed");
      $finish;
    end
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] nd,
                           input logic [LVL_W-1:0] lv, input logic [TIME_W-1:0] et,
                           input logic [TIME_W-1:0] lt, input logic [NODE_W-1:0] an,
                           input logic last, input logic has_typed = 1'b0,
                           input logic [NODE_W-1:0] typed = '0);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    node <= nd;
    level <= lv;
    enter_time <= et;
    leave_time <= lt;
    ancestor_node <= an;
    is_last <= last;
    typed_on <= has_typed;
    typed_ca <= typed;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_query(input logic [NODE_W-1:0] nd, input logic last);
    send_word(OP_QUERY, nd, LVL_W'($urandom), TIME_W'($urandom), TIME_W'($urandom),
              NODE_W'($urandom), last);
  endtask

  task automatic send_noise();
    logic [NODE_W-1:0] spot;
    spot = NODE_W'($urandom);
    while (in_tree[spot]) spot = NODE_W'($urandom);
    case ($urandom_range(2))
      0: send_word(OP_NONE, NODE_W'($urandom), LVL_W'($urandom), TIME_W'($urandom),
                   TIME_W'($urandom), NODE_W'($urandom), 1'($urandom));
      1: send_word(OP_TIMES, spot, LVL_W'($urandom), TIME_W'($urandom),
                   TIME_W'($urandom), NODE_W'($urandom), 1'($urandom));
      default: send_word(OP_LIFT, spot, LVL_W'($urandom), TIME_W'($urandom),
                         TIME_W'($urandom), NODE_W'($urandom), 1'($urandom));
    endcase
  endtask

  // preorder intervals from parent links, then every lift level of every tree node
  task automatic plant_tree(input int stride, input int offset);
    int span [MAX_TREE];
    int pos [MAX_TREE];
    int slot [MAX_TREE];
    int jump [LEVELS][MAX_TREE];
    for (int i = 0; i < NODES; i++) in_tree[i] = 1'b0;
    for (int i = 0; i < tree_size; i++) begin
      span[i] = 1;
      in_tree[tree_node[i]] = 1'b1;
    end
    for (int i = tree_size - 1; i > 0; i--) span[tree_par[i]] += span[i];
    pos[0] = 0;
    slot[0] = 1;
    jump[0][0] = 0;
    for (int i = 1; i < tree_size; i++) begin
      pos[i] = slot[tree_par[i]];
      slot[tree_par[i]] += span[i];
      slot[i] = pos[i] + 1;
      jump[0][i] = tree_par[i];
    end
    for (int k = 1; k < LEVELS; k++)
      for (int i = 0; i < tree_size; i++) jump[k][i] = jump[k-1][jump[k-1][i]];
    for (int i = 0; i < tree_size; i++) begin
      if ($urandom_range(9) == 0) send_noise();
      send_word(OP_TIMES, tree_node[i], LVL_W'($urandom), TIME_W'(pos[i] * stride + offset),
                TIME_W'((pos[i] + span[i] - 1) * stride + offset), NODE_W'($urandom),
                1'($urandom));
    end
    for (int k = 0; k < LEVELS; k++)
      for (int i = 0; i < tree_size; i++) begin
        if ($urandom_range(9) == 0) send_noise();
        send_word(OP_LIFT, tree_node[i], LVL_W'(k), TIME_W'($urandom), TIME_W'($urandom),
                  tree_node[jump[k][i]], 1'($urandom));
      end
  endtask

  task automatic run_phase(input int pct, input int words);
    int sent;
    int members;
    int stride;
    logic [NODE_W-1:0] pick;
    bit fresh;
    idle_pct = pct;
    sent = 0;
    tree_size = $urandom_range(4, 12);
    for (int i = 0; i < tree_size; i++) begin
      do begin
        pick = NODE_W'($urandom);
        fresh = 1'b1;
        for (int j = 0; j < i; j++) if (tree_node[j] == pick) fresh = 1'b0;
      end while (!fresh);
      tree_node[i] = pick;
      tree_par[i] = (i == 0) ? 0 : ($urandom_range(1) ? i - 1 : $urandom_range(i - 1));
    end
    stride = $urandom_range(1, 2047 / tree_size);
    plant_tree(stride, $urandom_range(2047 - (tree_size - 1) * stride));
    while (sent < words) begin
      case ($urandom_range(9))
        0: begin
          send_noise();
          sent++;
        end
        1: begin
          send_query(NODE_W'($urandom), 1'b1);
          sent++;
        end
        default: begin
          members = $urandom_range(1, 5);
          for (int m = 0; m < members; m++) begin
            if ($urandom_range(7) == 0) send_noise();
            send_query(tree_node[$urandom_range(tree_size - 1)], m == members - 1);
            sent++;
          end
        end
      endcase
    end
  endtask

  task automatic add_row(input row_t r);
    script.insert(script.size(), r);
  endtask

  initial begin
    // root 1023 with children 0 and 512; 341 under 0, 682 under 512
    add_row('{OP_QUERY, 10'd1023, 4'd15, 11'd2047, 11'd2047, 10'd1023, 1'b1, 1'b1,
              10'd1023});
    add_row('{OP_QUERY, 10'd0, 4'd0, 11'd0, 11'd0, 10'd0, 1'b1, 1'b1, 10'd0});
    add_row('{OP_QUERY, 10'd341, 4'd3, 11'd5, 11'd9, 10'd77, 1'b0, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd682, 4'd0, 11'd0, 11'd0, 10'd0, 1'b1, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd341, 4'd0, 11'd0, 11'd0, 10'd0, 1'b0, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd0, 4'd0, 11'd0, 11'd0, 10'd0, 1'b1, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd0, 4'd0, 11'd0, 11'd0, 10'd0, 1'b0, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd341, 4'd0, 11'd0, 11'd0, 10'd0, 1'b1, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd682, 4'd0, 11'd0, 11'd0, 10'd0, 1'b0, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd512, 4'd0, 11'd0, 11'd0, 10'd0, 1'b1, 1'b0, 10'd0});
    add_row('{OP_NONE, 10'd1023, 4'd15, 11'd2047, 11'd2047, 10'd1023, 1'b1, 1'b0,
              10'd0});
    add_row('{OP_TIMES, 10'd100, 4'd15, 11'd2047, 11'd0, 10'd1023, 1'b1, 1'b0, 10'd0});
    add_row('{OP_TIMES, 10'd101, 4'd0, 11'd0, 11'd2047, 10'd0, 1'b0, 1'b0, 10'd0});
    add_row('{OP_LIFT, 10'd100, 4'd15, 11'd2047, 11'd2047, 10'd1023, 1'b1, 1'b0,
              10'd0});
    add_row('{OP_LIFT, 10'd101, 4'd0, 11'd0, 11'd0, 10'd0, 1'b0, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd341, 4'd0, 11'd0, 11'd0, 10'd0, 1'b0, 1'b0, 10'd0});
    add_row('{OP_TIMES, 10'd102, 4'd0, 11'd1, 11'd1, 10'd0, 1'b1, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd341, 4'd0, 11'd0, 11'd0, 10'd0, 1'b1, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd0, 4'd0, 11'd0, 11'd0, 10'd0, 1'b0, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd682, 4'd0, 11'd0, 11'd0, 10'd0, 1'b0, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd341, 4'd0, 11'd0, 11'd0, 10'd0, 1'b1, 1'b0, 10'd0});
    add_row('{OP_QUERY, 10'd1023, 4'd15, 11'd2047, 11'd2047, 10'd1023, 1'b0, 1'b0,
              10'd0});
    add_row('{OP_QUERY, 10'd1023, 4'd15, 11'd2047, 11'd2047, 10'd1023, 1'b1, 1'b0,
              10'd0});
    add_row('{OP_QUERY, 10'd5, 4'd0, 11'd0, 11'd0, 10'd0, 1'b1, 1'b1, 10'd5});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    tree_size = 5;
    tree_node[0] = 10'd1023;
    tree_node[1] = 10'd0;
    tree_node[2] = 10'd512;
    tree_node[3] = 10'd341;
    tree_node[4] = 10'd682;
    tree_par[0] = 0;
    tree_par[1] = 0;
    tree_par[2] = 0;
    tree_par[3] = 1;
    tree_par[4] = 2;
    plant_tree(511, 0);
    foreach (script[i])
      send_word(script[i].op, script[i].nd, script[i].lv, script[i].et, script[i].lt,
                script[i].an, script[i].last, script[i].typed, script[i].want);

    run_phase(16, 40);
    run_phase(63, 40);
    run_phase(0, 40);
    start <= 1'b0;

    while (pending_ancestors.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_ancestors.size() == 0) begin
      $display("set_lca_binary_lifting_unit test passed");
    end else begin
      $display("set_lca_binary_lifting_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/slca_pkg.sv
rtl/slca_ram.sv
rtl/slca_ctrl.sv
rtl/slca_dp.sv
rtl/set_lca_binary_lifting_unit.sv
tb/set_lca_binary_lifting_unit_test.sv
